// ===== rtl/core/apc_pkg.sv =====
// package for the pulse channel: widths, register indexes, tables
// no dependencies
package apc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int STEP_W        = 24;

   typedef enum logic [2:0] {
      REG_DUTY   = 3'd0,
      REG_SWEEP  = 3'd1,
      REG_PLO    = 3'd2,
      REG_PHI    = 3'd3,
      REG_ENABLE = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   function automatic logic [7:0] length_lookup(input logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:  r = 8'd10;  5'd1:  r = 8'd254; 5'd2:  r = 8'd20;  5'd3:  r = 8'd2;
         5'd4:  r = 8'd40;  5'd5:  r = 8'd4;   5'd6:  r = 8'd80;  5'd7:  r = 8'd6;
         5'd8:  r = 8'd160; 5'd9:  r = 8'd8;   5'd10: r = 8'd60;  5'd11: r = 8'd10;
         5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
         5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
         5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
         5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
         5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] duty_lookup(input logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0:    r = 8'b00000001;
         2'd1:    r = 8'b00000011;
         2'd2:    r = 8'b00001111;
         default: r = 8'b11111100;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/apc_if.sv =====
// valid/ready channel interfaces for the pulse channel
// no dependencies
interface apc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] reg_index;
   logic [7:0] reg_value;
   logic       quarter_frame;
   logic       half_frame;
   modport source (output valid, req_type, reg_index, reg_value, quarter_frame, half_frame,
                   input ready);
   modport sink (input valid, req_type, reg_index, reg_value, quarter_frame, half_frame,
                 output ready);
endinterface

interface apc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample_level;
   modport source (output valid, sample_level, input ready);
   modport sink (input valid, sample_level, output ready);
endinterface

// ===== rtl/core/apu_pulse_channel.sv =====
// pulse channel top level: register decode, envelope, sweep, length, phase
// depends on apc_pkg and the channel interfaces in apc_if.sv
//
// Usage: req carries one word per register write or per sample tick. A write
// gives no rsp word. A tick gives exactly one rsp word carrying sample_level.
// csr_we/csr_wdata load the per-sample clock step; the user must assert them
// only while no tick is in work, as the block itself does not enforce it.
// Steps of a tick: envelope/sweep/length are done at the accepting edge,
// then the phase quotient is found by a restoring subtract-and-shift
// unit, one quotient bit a cycle for 12+FRAC_BITS+1 bits (29 at the default),
// then ST_DONE loads the output register once it is free and rsp_valid rises.
// Throughput: writes one a cycle while no tick is in work; a tick is taken
// only when the last one's result is loaded, as req_ready is low from the
// accepting edge until then.
// If the receiver stalls, the result holds in rsp until taken; the next tick
// may still run its division and then waits in its last step, keeping
// req_ready low, until the output register is free.
// Reset zeroes the step register and channel state, but not the divider or out_ff.
module apu_pulse_channel
   import apc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [STEP_W-1:0] csr_wdata,
   apc_req_if.sink           req,
   apc_rsp_if.source         rsp
);

   localparam int PW = 11 + FRAC_BITS;
   localparam int TW = 12 + FRAC_BITS;
   localparam int SW = TW + 1;
   localparam int CW = $clog2(SW + 1);
   localparam logic [PW-1:0] PMAX = {11'h7ff, {FRAC_BITS{1'b0}}};

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff;
   logic [7:0] duty_ff;
   logic env_const_ff, env_loop_ff, env_start_ff;
   logic [3:0] env_vol_ff, env_div_ff, env_decay_ff;
   logic [7:0] sweep_ff;
   logic [2:0] sweep_div_ff;
   logic [PW-1:0] period_ff;
   logic [TW-1:0] accum_ff;
   logic [7:0] len_ff;
   logic [2:0] phase_ff;
   logic [SW-1:0] dividend_ff;
   logic [PW-1:0] rem_ff;
   logic [2:0] quot_ff;
   logic [CW-1:0] cnt_ff;
   logic [3:0] vol_ff;
   logic [3:0] out_ff;
   logic out_valid_ff;

   logic accept;
   logic done_go;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign done_go = (state_ff == ST_DONE) && (!out_valid_ff || rsp.ready);
   assign rsp.valid = out_valid_ff;
   assign rsp.sample_level = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && req.req_type) state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == CW'(SW - 1)) state_in = ST_DONE;
         ST_DONE: if (!out_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // tick front end, combinational from current state
   logic env_start_n;
   logic [3:0] env_div_n, env_decay_n, vol_n;
   logic [2:0] sweep_div_n;
   logic [PW-1:0] period_n, change, target;
   logic [PW:0] tgt_full;
   logic over;
   logic gate;
   logic [7:0] len_n;
   always_comb begin
      env_start_n = env_start_ff;
      env_div_n = env_div_ff;
      env_decay_n = env_decay_ff;
      if (req.quarter_frame) begin
         if (env_start_ff) begin
            env_start_n = 1'b0;
            env_decay_n = 4'd15;
            env_div_n = env_vol_ff;
         end else if (env_div_ff != 4'd0) begin
            env_div_n = env_div_ff - 4'd1;
         end else begin
            env_div_n = env_vol_ff;
            if (env_decay_ff != 4'd0) env_decay_n = env_decay_ff - 4'd1;
            else if (env_loop_ff) env_decay_n = 4'd15;
         end
      end
      vol_n = env_const_ff ? env_vol_ff : env_decay_n;
      gate = 1'b1;
      sweep_div_n = sweep_div_ff;
      period_n = period_ff;
      change = period_ff >> sweep_ff[2:0];
      if (sweep_ff[3]) tgt_full = {1'b0, period_ff - change};
      else tgt_full = {1'b0, period_ff} + {1'b0, change};
      over = (tgt_full >= {1'b0, PMAX});
      target = over ? PMAX : tgt_full[PW-1:0];
      if (sweep_ff[7] && req.half_frame) begin
         if (sweep_div_ff < sweep_ff[6:4]) begin
            sweep_div_n = sweep_div_ff + 3'd1;
         end else begin
            sweep_div_n = 3'd0;
            if (over) gate = 1'b0;
            period_n = target;
         end
      end
      len_n = len_ff;
      if (req.half_frame && !env_loop_ff && len_ff != 8'd0) len_n = len_ff - 8'd1;
      if (!gate || period_n[PW-1:FRAC_BITS] < 11'd8 || len_n == 8'd0) vol_n = 4'd0;
   end

   logic [PW+1:0] trial;
   assign trial = {1'b0, rem_ff, dividend_ff[SW-1]} - {2'b00, period_ff};

   logic [SW-1:0] dsum;
   assign dsum = {1'b0, accum_ff} + SW'(step_ff);

   logic [2:0] phase_sum, phase_sel;
   assign phase_sum = phase_ff + quot_ff;
   assign phase_sel = (period_ff != '0) ? phase_sum : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff <= '0;
         duty_ff <= '0;
         env_const_ff <= 1'b0;
         env_loop_ff <= 1'b0;
         env_start_ff <= 1'b0;
         env_vol_ff <= '0;
         env_div_ff <= '0;
         env_decay_ff <= '0;
         sweep_ff <= '0;
         sweep_div_ff <= '0;
         period_ff <= '0;
         accum_ff <= '0;
         len_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) step_ff <= csr_wdata;
         if (done_go) out_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         if (accept && !req.req_type) begin
            case (req.reg_index)
               REG_DUTY: begin
                  duty_ff <= duty_lookup(req.reg_value[7:6]);
                  env_const_ff <= req.reg_value[4];
                  env_loop_ff <= req.reg_value[5];
                  env_vol_ff <= req.reg_value[3:0];
                  env_start_ff <= !req.reg_value[4];
                  if (!req.reg_value[4]) env_div_ff <= req.reg_value[3:0];
               end
               REG_SWEEP: begin
                  sweep_ff <= req.reg_value;
                  sweep_div_ff <= 3'd0;
               end
               REG_PLO: period_ff[FRAC_BITS+7:FRAC_BITS] <= req.reg_value;
               REG_PHI: begin
                  period_ff[PW-1:FRAC_BITS+8] <= req.reg_value[2:0];
                  accum_ff <= '0;
                  len_ff <= length_lookup(req.reg_value[7:3]);
                  phase_ff <= 3'd0;
               end
               REG_ENABLE: if (!req.reg_value[0]) len_ff <= 8'd0;
               default: ;
            endcase
         end
         if (accept && req.req_type) begin
            env_start_ff <= env_start_n;
            env_div_ff <= env_div_n;
            env_decay_ff <= env_decay_n;
            sweep_div_ff <= sweep_div_n;
            period_ff <= period_n;
            len_ff <= len_n;
         end
         if (done_go) begin
            if (period_ff != '0) begin
               accum_ff <= {1'b0, rem_ff};
               phase_ff <= phase_sum;
            end else begin
               accum_ff <= dsum[TW-1:0];
            end
            out_ff <= duty_ff[phase_sel] ? vol_ff : 4'd0;
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (accept && req.req_type) begin
         vol_ff <= vol_n;
         dividend_ff <= dsum;
         rem_ff <= '0;
         quot_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff + CW'(1);
         dividend_ff <= {dividend_ff[SW-2:0], 1'b0};
         if (!trial[PW+1]) begin
            rem_ff <= trial[PW-1:0];
            quot_ff <= {quot_ff[1:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[PW-2:0], dividend_ff[SW-1]};
            quot_ff <= {quot_ff[1:0], 1'b0};
         end
      end
   end

endmodule

// ===== tb/sv/tb_apu_pulse_channel.sv =====
// testbench for the pulse channel: directed and random register writes and ticks,
// results predicted in a local model and compared word by word
// depends on apc_pkg, apc_if.sv and apu_pulse_channel
module tb_apu_pulse_channel;
   import apc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRAC_BITS_DEF;
   localparam int WDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [STEP_W-1:0] csr_wdata = '0;

   apc_req_if req ();
   apc_rsp_if rsp ();

   apu_pulse_channel #(.FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // model state
   logic [23:0]    m_step;
   logic [7:0]     m_duty;
   logic           m_const, m_loop, m_start;
   logic [3:0]     m_vol, m_div, m_decay;
   logic [7:0]     m_sweep;
   logic [2:0]     m_swdiv;
   logic [FB+10:0] m_period;
   logic [FB+11:0] m_accum;
   logic [7:0]     m_len;
   logic [2:0]     m_phase;

   logic [3:0] level_q[$];
   int errors = 0;
   int words_sent = 0;
   int levels_seen = 0;
   int idle_cycles = 0;
   bit rsp_hold = 0;
   bit rsp_noidle = 0;
   bit req_noidle = 0;

   task automatic report(input string what, input logic [3:0] got, input logic [3:0] exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   task automatic model_reset();
      m_step = 0; m_duty = 0; m_const = 0; m_loop = 0; m_start = 0;
      m_vol = 0; m_div = 0; m_decay = 0; m_sweep = 0; m_swdiv = 0;
      m_period = 0; m_accum = 0; m_len = 0; m_phase = 0;
   endtask

   function automatic logic [7:0] length_lookup_tb(input logic [4:0] i);
      logic [7:0] rom [32];
      rom = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
              8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
              8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
              8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
      return rom[i];
   endfunction

   task automatic model_word(input logic typ, input logic [2:0] idx, input logic [7:0] v,
                             input logic qf, input logic hf);
      logic [3:0] vol;
      logic gate;
      logic [FB+11:0] chg, tgt;
      logic [FB+12:0] t, q;
      if (!typ) begin
         case (idx)
            REG_DUTY: begin
               case (v[7:6])
                  2'd0: m_duty = 8'b00000001;
                  2'd1: m_duty = 8'b00000011;
                  2'd2: m_duty = 8'b00001111;
                  default: m_duty = 8'b11111100;
               endcase
               m_const = v[4]; m_loop = v[5]; m_vol = v[3:0]; m_start = 0;
               if (!m_const) begin
                  m_start = 1; m_div = m_vol;
               end
            end
            REG_SWEEP: begin
               m_sweep = v; m_swdiv = 0;
            end
            REG_PLO: m_period[FB+7:FB] = v;
            REG_PHI: begin
               m_period[FB+10:FB+8] = v[2:0];
               m_accum = 0; m_phase = 0;
               m_len = length_lookup_tb(v[7:3]);
            end
            REG_ENABLE: if (!v[0]) m_len = 0;
            default: ;
         endcase
         return;
      end
      if (qf) begin
         if (m_start) begin
            m_start = 0; m_decay = 15; m_div = m_vol;
         end else if (m_div > 0) begin
            m_div--;
         end else begin
            m_div = m_vol;
            if (m_decay > 0) m_decay--;
            else if (m_loop) m_decay = 15;
         end
      end
      vol = m_const ? m_vol : m_decay;
      gate = 1;
      if (m_sweep[7] && hf) begin
         if (m_swdiv < m_sweep[6:4]) begin
            m_swdiv++;
         end else begin
            m_swdiv = 0;
            chg = {1'b0, m_period} >> m_sweep[2:0];
            if (m_sweep[3]) tgt = (chg > m_period) ? '0 : {1'b0, m_period} - chg;
            else tgt = {1'b0, m_period} + chg;
            if (tgt >= ({{(FB+1){1'b0}}, 11'h7ff} << FB)) begin
               tgt = {{(FB+1){1'b0}}, 11'h7ff} << FB; gate = 0;
            end
            m_period = tgt[FB+10:0];
         end
      end
      if (!gate) vol = 0;
      if (hf && !m_loop && m_len > 0) m_len--;
      if (m_period[FB+10:FB] < 8) vol = 0;
      if (m_len == 0) vol = 0;
      t = {1'b0, m_accum} + m_step;
      if (m_period != 0) begin
         q = t / m_period;
         t = t - q * m_period;
         m_phase = m_phase + q[2:0];
      end
      m_accum = t[FB+11:0];
      level_q.push_back(m_duty[m_phase] ? vol : 4'd0);
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 4);
   endfunction

   // sender
   task automatic send_word(input logic typ, input logic [2:0] idx, input logic [7:0] v,
                            input logic qf, input logic hf);
      int g;
      g = req_noidle ? 0 : gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= typ; req.reg_index <= idx; req.reg_value <= v;
      req.quarter_frame <= qf; req.half_frame <= hf;
      do @(posedge clock); while (!req.ready);
      model_word(typ, idx, v, qf, hf);
      words_sent++;
   endtask

   task automatic wr(input logic [2:0] idx, input logic [7:0] v);
      send_word(1'b0, idx, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic tick(input logic qf, input logic hf);
      send_word(1'b1, 3'($urandom), 8'($urandom), qf, hf);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (level_q.size() != 0) @(posedge clock);
      repeat (FB + 40) @(posedge clock);
   endtask

   task automatic set_step(input logic [23:0] s);
      drain();
      csr_we <= 1'b1; csr_wdata <= s;
      @(posedge clock);
      csr_we <= 1'b0;
      m_step = s;
   endtask

   // receiver and checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         levels_seen++;
         if (level_q.size() == 0) begin
            report("unexpected word", rsp.sample_level, 4'd0);
         end else begin
            logic [3:0] e;
            e = level_q.pop_front();
            if (rsp.sample_level !== e) report("sample_level", rsp.sample_level, e);
         end
      end
   end

   initial begin
      int g;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold) begin
            rsp.ready <= 1'b0;
            @(posedge clock);
         end else begin
            g = rsp_noidle ? 0 : gap_len();
            if (g > 0) begin
               rsp.ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic rand_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) tick($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      else if (r < 68) wr(3'($urandom_range(5, 7)), 8'($urandom));
      else wr(3'($urandom_range(0, 4)), 8'($urandom));
   endtask

   task automatic test_directed();
      set_step(24'hffffff);
      tick(1'b1, 1'b1);
      wr(REG_DUTY, 8'hbf);
      wr(REG_PLO, 8'hff);
      wr(REG_PHI, 8'hff);
      tick(1'b1, 1'b1);
      wr(REG_SWEEP, 8'h80);
      tick(1'b0, 1'b1);
      wr(REG_SWEEP, 8'hff);
      wr(REG_PLO, 8'h00);
      wr(REG_PHI, 8'h00);
      tick(1'b1, 1'b1);
      wr(REG_PLO, 8'h07);
      tick(1'b1, 1'b0);
      wr(REG_DUTY, 8'h4a);
      wr(REG_PLO, 8'h40);
      wr(REG_PHI, 8'h08);
      tick(1'b1, 1'b1);
      tick(1'b1, 1'b0);
      wr(REG_ENABLE, 8'h01);
      tick(1'b0, 1'b0);
      wr(REG_ENABLE, 8'h00);
      tick(1'b0, 1'b0);
      wr(3'd7, 8'hff);
      tick(1'b1, 1'b1);
   endtask

   task automatic test_sweep_envelope();
      set_step(24'h000000);
      wr(REG_DUTY, 8'hff);
      wr(REG_PLO, 8'h00); wr(REG_PHI, 8'h00);
      tick(1'b1, 1'b1);
      set_step(24'h0a0000);
      repeat (40) begin
         wr(REG_DUTY, 8'($urandom)); wr(REG_SWEEP, 8'($urandom) | 8'h80);
         wr(REG_PLO, 8'($urandom)); wr(REG_PHI, 8'($urandom));
         repeat ($urandom_range(3, 12))
            tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random();
      logic [23:0] steps[4];
      steps = '{24'h3a_0000, 24'h00_0001, 24'($urandom), 24'h12_3456};
      foreach (steps[k]) begin
         set_step(steps[k]);
         repeat (270) rand_word();
      end
   endtask

   task automatic test_backpressure();
      int n;
      rsp_hold = 1;
      req_noidle = 1;
      fork
         begin
            n = 0;
            while (n < 200) begin
               @(posedge clock); n++;
            end
            rsp_hold = 0;
         end
         repeat (6) tick(1'b1, 1'b1);
      join
      req_noidle = 0;
      drain();
      rsp_noidle = 1;
      req_noidle = 1;
      repeat (100) rand_word();
      rsp_noidle = 0;
      req_noidle = 0;
   endtask

   initial begin
      req.valid = 1'b0; req.req_type = 1'b0; req.reg_index = '0; req.reg_value = '0;
      req.quarter_frame = 1'b0; req.half_frame = 1'b0;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sweep_envelope();
      test_random();
      test_backpressure();
      drain();
      $display("sent %0d words, checked %0d sample levels across several step values",
               words_sent, levels_seen);
      $display("covered sweep clamp, envelope decay, length load and a long output stall");
      if (errors == 0 && level_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d levels outstanding", errors, level_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
